@@ design/vca_pkg.sv @@
// ----------------------------------------------------------------------------
// Voice channel allocator package
// Shared sizes, note constants and the sequencer state type.
// ----------------------------------------------------------------------------
package vca_pkg;

  // Number of synthesizer channels held in the block.
  localparam int unsigned NUM_CH = 9;
  localparam int unsigned CH_W   = $clog2(NUM_CH);
  localparam int unsigned CNT_W  = $clog2(NUM_CH + 1);

  // Field widths of the command and result ports.
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned BLOCK_W = 3;
  localparam int unsigned SCALE_W = 5;
  localparam int unsigned MASK_W  = 9;

  // Highest note that may key on, and the octave layout of the pitch table.
  localparam logic [NOTE_W-1:0] KEY_ON_MAX = NOTE_W'(114);
  localparam logic [NOTE_W-1:0] NOTE_BASE  = NOTE_W'(19);
  localparam int unsigned       OCT_LEN    = 12;

  // Divide by twelve: multiply by 171 and shift right by 11 (exact for 0..95).
  localparam int unsigned RECIP       = 171;
  localparam int unsigned RECIP_W     = 8;
  localparam int unsigned RECIP_SHIFT = 11;

  localparam logic CFG_RESET_HI = 1'b1;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(9);

  // Event kinds.
  localparam logic KIND_ON  = 1'b0;
  localparam logic KIND_OFF = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

endpackage

@@ design/voice_channel_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// Voice channel allocator
// Assigns synthesizer channels to note-on items and releases them on
// note-off items, with one scan over the channels per item.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-------------------------------
//  command   | in        | start_i, busy_o            | kind_i, note_i, now_i
//  result    | out       | result_valid_o (strobe)    | channel_o, key_on_o, block_o,
//            |           |                            | scale_index_o, off_mask_o
//  config    | in        | cfg_valid_i, cfg_ready_o   | cfg_data_i (channels_in_use)
//
// Steps: after the accepting edge the scan visits n = min(channels_in_use,
// NUM_CH) channels, one per cycle, through the single shared time/note
// comparator; an end step then ends the scan, the write state commits the
// chosen channel, and the result strobe is registered from the write state.
// The result strobe lasts one cycle and overlaps the idle state, so a new item
// can be taken while it is shown.
// Reset clears all channel state and sets channels_in_use to nine. The result
// receiver cannot stall; cfg_ready_o is always high.

module voice_channel_allocator_unit
  import vca_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 kind_i,
  input  logic [NOTE_W-1:0]    note_i,
  input  logic [TIME_W-1:0]    now_i,
  // result
  output logic                 result_valid_o,
  output logic [CHAN_W-1:0]    channel_o,
  output logic                 key_on_o,
  output logic [BLOCK_W-1:0]   block_o,
  output logic [SCALE_W-1:0]   scale_index_o,
  output logic [MASK_W-1:0]    off_mask_o,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // Per-channel state, one register set per channel.
  logic              sounding_q [NUM_CH];
  logic [NOTE_W-1:0] held_q     [NUM_CH];
  logic [TIME_W-1:0] time_q     [NUM_CH];

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  cfg_q;

  // Latched item.
  logic              kind_q;
  logic [NOTE_W-1:0] note_q;
  logic [TIME_W-1:0] now_q;

  // Scan registers.
  logic [CNT_W-1:0]  cnt_q, act_q;
  logic [TIME_W-1:0] best_on_t_q, best_off_t_q;
  logic [CH_W-1:0]   best_on_q, best_off_q;
  logic              have_on_q, have_off_q;
  logic [NUM_CH-1:0] mask_q;

  // Result registers.
  logic               res_valid_q;
  logic [CHAN_W-1:0]  res_chan_q;
  logic               res_key_q;
  logic [BLOCK_W-1:0] res_block_q;
  logic [SCALE_W-1:0] res_scale_q;
  logic [MASK_W-1:0]  res_mask_q;

  // Active channel count, saturated to the number held.
  logic [31:0]      cfg_ext;
  logic [CNT_W-1:0] act_n;

  always_comb begin
    cfg_ext = 32'(cfg_q);
    act_n   = (cfg_ext > 32'(NUM_CH)) ? CNT_W'(NUM_CH) : CNT_W'(cfg_ext);
  end

  // Shared comparator: looks at the channel under the scan counter.
  logic [CH_W-1:0]   scan_idx;
  logic              scan_end;
  logic              cur_snd;
  logic [TIME_W-1:0] cur_time;
  logic [TIME_W-1:0] cmp_ref;
  logic              older;
  logic              note_hit;

  always_comb begin
    scan_idx = cnt_q[CH_W-1:0];
    scan_end = (cnt_q == act_q);
    cur_snd  = sounding_q[scan_idx];
    cur_time = time_q[scan_idx];
    cmp_ref  = cur_snd ? best_on_t_q : best_off_t_q;
    older    = (cur_time < cmp_ref);
    note_hit = (held_q[scan_idx] == note_q);
  end

  // Channel chosen for a note on: longest released, else longest sounding,
  // else channel zero.
  logic [CH_W-1:0] pick;

  always_comb begin
    if (have_off_q) begin
      pick = best_off_q;
    end else if (have_on_q) begin
      pick = best_on_q;
    end else begin
      pick = '0;
    end
  end

  // Pitch mapping for the latched note.
  logic [NOTE_W-1:0]          note_ofs;
  logic [NOTE_W+RECIP_W-1:0]  quot_prod;
  logic [BLOCK_W-1:0]         oct;
  logic [NOTE_W-1:0]          rem;
  logic                       key_ok;
  logic [BLOCK_W-1:0]         blk_val;
  logic [SCALE_W-1:0]         scl_val;

  always_comb begin
    note_ofs  = note_q - NOTE_BASE;
    quot_prod = (NOTE_W+RECIP_W)'(note_ofs) * (NOTE_W+RECIP_W)'(RECIP);
    oct       = quot_prod[RECIP_SHIFT +: BLOCK_W];
    rem       = note_ofs - NOTE_W'(oct) * NOTE_W'(OCT_LEN);
    key_ok    = (note_q <= KEY_ON_MAX);
    if (!key_ok) begin
      blk_val = '0;
      scl_val = '0;
    end else if (note_q < NOTE_BASE) begin
      blk_val = '0;
      scl_val = note_q[SCALE_W-1:0];
    end else begin
      blk_val = oct;
      scl_val = SCALE_W'(rem) + SCALE_W'(NOTE_BASE);
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_SCAN;
      ST_SCAN:  if (scan_end) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Item latch and scan bookkeeping.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        // Latch the item and seed the search with the event time.
        if (start_i) begin
          kind_q       <= kind_i;
          note_q       <= note_i;
          now_q        <= now_i;
          act_q        <= act_n;
          cnt_q        <= '0;
          best_on_t_q  <= now_i;
          best_off_t_q <= now_i;
          best_on_q    <= '0;
          best_off_q   <= '0;
          have_on_q    <= 1'b0;
          have_off_q   <= 1'b0;
          mask_q       <= '0;
        end
      end
      ST_SCAN: begin
        if (!scan_end) begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (kind_q == KIND_ON) begin
            if (older) begin
              if (cur_snd) begin
                best_on_t_q <= cur_time;
                best_on_q   <= scan_idx;
                have_on_q   <= 1'b1;
              end else begin
                best_off_t_q <= cur_time;
                best_off_q   <= scan_idx;
                have_off_q   <= 1'b1;
              end
            end
          end else if (note_hit) begin
            mask_q[scan_idx] <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Channel state: release during a note-off scan, claim at note-on commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sounding_q[i] <= 1'b0;
        held_q[i]     <= '0;
        time_q[i]     <= '0;
      end
    end else begin
      if (state_q == ST_SCAN && !scan_end && kind_q == KIND_OFF && note_hit) begin
        sounding_q[scan_idx] <= 1'b0;
        time_q[scan_idx]     <= now_q;
      end
      if (state_q == ST_WRITE && kind_q == KIND_ON) begin
        sounding_q[pick] <= 1'b1;
        held_q[pick]     <= note_q;
        time_q[pick]     <= now_q;
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (state_q == ST_WRITE);
    end
  end

  // Result payload, truncated to the port widths.
  logic [31:0] pick_ext, mask_ext;

  always_comb begin
    pick_ext = 32'(pick);
    mask_ext = 32'(mask_q);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) begin
      if (kind_q == KIND_ON) begin
        res_chan_q  <= pick_ext[CHAN_W-1:0];
        res_key_q   <= key_ok;
        res_block_q <= blk_val;
        res_scale_q <= scl_val;
        res_mask_q  <= '0;
      end else begin
        res_chan_q  <= '0;
        res_key_q   <= 1'b0;
        res_block_q <= '0;
        res_scale_q <= '0;
        res_mask_q  <= mask_ext[MASK_W-1:0];
      end
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign cfg_ready_o    = CFG_RESET_HI;
  assign result_valid_o = res_valid_q;
  assign channel_o      = res_chan_q;
  assign key_on_o       = res_key_q;
  assign block_o        = res_block_q;
  assign scale_index_o  = res_scale_q;
  assign off_mask_o     = res_mask_q;

endmodule
